// ===== design/cswe_pkg.sv =====
// Package for the count-based sliding window emitter.
// Holds widths and register map used by all modules, and the control struct from the sequencer to the cell row.
// No dependencies.
package cswe_pkg;

  // Data word width and window buffer depth
  localparam int DATA_WIDTH   = 32;
  localparam int WINDOW_DEPTH = 16;

  // Pointer indexes one buffer entry; size counts 1..WINDOW_DEPTH
  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SIZE_W = $clog2(WINDOW_DEPTH + 1);

  // Register field widths
  localparam int CFG_SIZE_W = 5;
  localparam int STEP_W     = 16;

  // Config port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register indexes (taken from paddr[2])
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_STEP_COUNT  = 1'b1;

  // Register reset values
  localparam logic [CFG_SIZE_W-1:0] WINDOW_SIZE_RST = CFG_SIZE_W'(16);
  localparam logic [STEP_W-1:0]     STEP_COUNT_RST  = STEP_W'(1);

  // Control from the sequencer to the cell row
  typedef struct packed {
    logic              wr_en;     // write sample into cell at wr_ptr
    logic [PTR_W-1:0]  wr_ptr;
    logic              shift_en;  // rotate the active ring by one
    logic [SIZE_W-1:0] size;      // effective window size, 1..WINDOW_DEPTH
  } cell_ctl_t;

  // Clamp the size register to 1..WINDOW_DEPTH
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (32'(s) > 32'(WINDOW_DEPTH)) begin
      r = SIZE_W'(WINDOW_DEPTH);
    end else begin
      r = SIZE_W'(s);
    end
    return r;
  endfunction

endpackage

// ===== design/cswe_cell.sv =====
// One window cell: holds a single data word.
// Loads a new sample or takes its neighbor's word during ring rotation.
// Depends on cswe_pkg.
module cswe_cell (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [cswe_pkg::DATA_WIDTH-1:0]  wr_data,
  input  logic                             shift_en,
  input  logic [cswe_pkg::DATA_WIDTH-1:0]  shift_data,
  output logic [cswe_pkg::DATA_WIDTH-1:0]  q
);

  logic [cswe_pkg::DATA_WIDTH-1:0] word_r;
  logic [cswe_pkg::DATA_WIDTH-1:0] word_nxt;

  // Write and rotate never coincide; write wins anyway
  always_comb begin
    word_nxt = word_r;
    if (wr_en) begin
      word_nxt = wr_data;
    end else if (shift_en) begin
      word_nxt = shift_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

// ===== design/cswe_ctrl.sv =====
// Sequencer: write pointer, stride counter, full flag, emission counter
// and the output register. Drives the cell row through cell_ctl_t.
// Depends on cswe_pkg.
module cswe_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [cswe_pkg::CFG_SIZE_W-1:0]     cfg_size,
  input  logic [cswe_pkg::STEP_W-1:0]         cfg_step,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cswe_pkg::DATA_WIDTH-1:0]     tap_data,
  output cswe_pkg::cell_ctl_t                 cell_ctl,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cswe_pkg::DATA_WIDTH-1:0]     out_value,
  output logic                                out_last
);

  localparam int PW = cswe_pkg::PTR_W;
  localparam int SW = cswe_pkg::SIZE_W;
  localparam int TW = cswe_pkg::STEP_W;

  logic [PW-1:0] wp_r, wp_nxt;
  logic [TW-1:0] sc_r, sc_nxt;
  logic          full_r, full_nxt;
  logic          emit_r, emit_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [cswe_pkg::DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;

  logic [SW-1:0] size;
  logic          in_acc;
  logic          out_free;
  logic          step_go;
  logic          is_last;
  logic [SW:0]   ptr_inc;
  logic [TW-1:0] sc_inc;
  logic          bound;
  logic          wrap;

  assign size     = cswe_pkg::eff_size(cfg_size);
  assign in_acc   = in_valid && !emit_r;
  assign out_free = !out_valid_r || !out_stall;
  assign step_go  = emit_r && out_free;
  assign is_last  = (cnt_r == size - SW'(1));

  // Pointer wrap and stride boundary for an accepted request
  assign ptr_inc = (SW+1)'(wp_r) + (SW+1)'(1);
  assign wrap    = (ptr_inc >= (SW+1)'(size));
  assign sc_inc  = sc_r + TW'(1);
  assign bound   = (sc_inc == '0) || ((cfg_step != '0) && (sc_inc >= cfg_step));

  always_comb begin
    wp_nxt        = wp_r;
    sc_nxt        = sc_r;
    full_nxt      = full_r;
    emit_nxt      = emit_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    // New sample: advance pointer and stride, maybe start an emission
    if (in_acc) begin
      if (wrap) begin
        wp_nxt   = '0;
        full_nxt = 1'b1;
      end else begin
        wp_nxt = PW'(ptr_inc);
      end
      if (bound) begin
        sc_nxt = '0;
        if (full_nxt) begin
          emit_nxt = 1'b1;
          cnt_nxt  = '0;
        end
      end else begin
        sc_nxt = sc_inc;
      end
    end

    // Output register: load next window entry or drain
    if (step_go) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = tap_data;
      out_last_nxt  = is_last;
      cnt_nxt       = cnt_r + SW'(1);
      if (is_last) begin
        emit_nxt = 1'b0;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      sc_r        <= '0;
      full_r      <= 1'b0;
      emit_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      sc_r        <= sc_nxt;
      full_r      <= full_nxt;
      emit_r      <= emit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Cell row control; the tap sits at the write pointer
  assign cell_ctl.wr_en    = in_acc;
  assign cell_ctl.wr_ptr   = wp_r;
  assign cell_ctl.shift_en = step_go;
  assign cell_ctl.size     = size;

  assign in_stall  = emit_r;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/count_sliding_window_emitter.sv =====
// Count-based sliding window emitter.
//
// Input channel (in_*): one sample per request, appended to a circular
// window of window_size entries. Every step_count requests a stride
// boundary occurs; once the window has wrapped at least once, the boundary
// emits the whole window on the output channel (out_*), oldest entry
// first, window_size results, the newest flagged by out_window_last.
// A request that emits nothing is taken every cycle while no emission runs.
// A request that emits holds in_stall high until the last result is loaded,
// while the emission runs at one result per cycle unless stalled, the pace
// set by the single output register and the rotating ring of window cells;
// the triggering request sets the emit flag and the output register then
// loads the first result. out_stall freezes the output register and the
// ring; nothing is lost. The last result may wait while the next request
// is already accepted. Configuration is through an APB-style port:
// window_size at 0x0, step_count at 0x4, written by the user only while
// the block is idle; the block does not enforce this. Reset (rst_n low,
// synchronous) clears pointer, stride counter, full flag and output valid,
// and sets window_size to 16 and step_count to 1. Window cell contents are
// undefined until written. Depends on cswe_pkg, cswe_cell and cswe_ctrl.
module count_sliding_window_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cswe_pkg::DATA_WIDTH-1:0]     in_sample_value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cswe_pkg::DATA_WIDTH-1:0]     out_window_value,
  output logic                                out_window_last,
  // Config port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cswe_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cswe_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cswe_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int DW = cswe_pkg::DATA_WIDTH;
  localparam int DP = cswe_pkg::WINDOW_DEPTH;
  localparam int SW = cswe_pkg::SIZE_W;

  logic [cswe_pkg::CFG_SIZE_W-1:0] size_r, size_nxt;
  logic [cswe_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                            cfg_wr;
  logic                            cfg_sel;

  cswe_pkg::cell_ctl_t cell_ctl;
  logic [DW-1:0] cell_q    [DP];
  logic [DW-1:0] cell_feed [DP];
  logic [DP-1:0] cell_wr;
  logic [DP-1:0] cell_shift;
  logic [DW-1:0] tap_data;

  // Register write
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    size_nxt = size_r;
    step_nxt = step_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        cswe_pkg::REG_WINDOW_SIZE: size_nxt = cfg_pwdata[cswe_pkg::CFG_SIZE_W-1:0];
        cswe_pkg::REG_STEP_COUNT:  step_nxt = cfg_pwdata[cswe_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= cswe_pkg::WINDOW_SIZE_RST;
      step_r <= cswe_pkg::STEP_COUNT_RST;
    end else begin
      size_r <= size_nxt;
      step_r <= step_nxt;
    end
  end

  // Register read
  always_comb begin
    unique case (cfg_sel)
      cswe_pkg::REG_WINDOW_SIZE: cfg_prdata = cswe_pkg::CFG_DATA_W'(size_r);
      cswe_pkg::REG_STEP_COUNT:  cfg_prdata = cswe_pkg::CFG_DATA_W'(step_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Sequencer
  cswe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_size  (size_r),
    .cfg_step  (step_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tap_data  (tap_data),
    .cell_ctl  (cell_ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_window_value),
    .out_last  (out_window_last)
  );

  // Cell row: the first size cells form a ring that rotates toward cell 0
  for (genvar i = 0; i < DP; i++) begin : g_cell
    assign cell_wr[i]    = cell_ctl.wr_en && (cell_ctl.wr_ptr == cswe_pkg::PTR_W'(i));
    assign cell_shift[i] = cell_ctl.shift_en && ((SW+1)'(i) < (SW+1)'(cell_ctl.size));

    if (i == DP - 1) begin : g_end
      assign cell_feed[i] = cell_q[0];
    end else begin : g_mid
      assign cell_feed[i] = ((SW+1)'(i) == (SW+1)'(cell_ctl.size) - (SW+1)'(1)) ?
                            cell_q[0] : cell_q[i+1];
    end

    cswe_cell u_cell (
      .clk        (clk),
      .wr_en      (cell_wr[i]),
      .wr_data    (in_sample_value),
      .shift_en   (cell_shift[i]),
      .shift_data (cell_feed[i]),
      .q          (cell_q[i])
    );
  end

  // Output tap at the write pointer: after k rotations it holds entry wp+k
  assign tap_data = cell_q[cell_ctl.wr_ptr];

endmodule
